// ===== hdl/fbfl_pkg.sv =====
// package: types, codes and constants of the fixed block free list allocator
`timescale 1ns / 1ps

package fbfl_pkg;

    localparam int MAX_BLOCKS = 64;
    localparam int IDX_W      = 6;
    localparam int CNT_W      = 7;
    localparam int ADDR_W     = 32;
    localparam int SIZE_W     = 16;
    localparam int CFG_W      = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int IN_W       = 8;
    localparam int OUT_W      = 40;

    typedef enum logic [1:0] {
        ACT_INIT = 2'd0,
        ACT_GET  = 2'd1,
        ACT_FREE = 2'd2,
        ACT_NOP  = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_EMPTY  = 2'd1,
        ST_DOUBLE = 2'd2,
        ST_RANGE  = 2'd3
    } status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BASE_ADDRESS = 2'd0,
        CFG_BLOCK_SIZE   = 2'd1,
        CFG_BLOCK_COUNT  = 2'd2,
        CFG_UNUSED       = 2'd3
    } cfg_reg_t;

endpackage

// ===== hdl/fbfl_ram.sv =====
// generic single write port ram with registered read
`timescale 1ns / 1ps

module fbfl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== hdl/fixed_block_free_list_allocator.sv =====
// top level: fixed size block pool with a last-in first-out free list
//
//   channel   | direction | tdata fields (lowest bit up)
//   s_axis    | in        | action[1:0], block_index[7:2]
//   m_axis    | out       | status[1:0], granted_index[7:2], granted_address[39:8]
//   cfg       | in        | cfg_index selects base address, block bytes, block count
//
// one transaction per cycle; each request is decided in the cycle it is accepted
// and its result sits in the output register from the next cycle on
// the top of the freed stack lives in a register, the rest in a ram whose registered
// read is addressed from the next depth, with a bypass for a same-address write
// a stall on m_axis holds s_axis only while the output register is full
// reset empties the pool and restores the register defaults, no clearing pass
`timescale 1ns / 1ps

module fixed_block_free_list_allocator
    import fbfl_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [IN_W-1:0]      s_axis_tdata,   // action, block_index
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [OUT_W-1:0]     m_axis_tdata    // status, granted_index, granted_address
);

    logic [ADDR_W-1:0]     base_reg;
    logic [SIZE_W-1:0]     size_reg;
    logic [CNT_W-1:0]      count_reg;

    logic [CNT_W-1:0]      depth_reg, depth_next;
    logic [CNT_W-1:0]      untouched_reg, untouched_next;
    logic [MAX_BLOCKS-1:0] marks_reg, marks_next;
    logic [IDX_W-1:0]      tos_reg, tos_next;
    logic                  byp_reg, byp_next;
    logic [IDX_W-1:0]      byp_data_reg;

    logic                  out_valid_reg;
    logic [OUT_W-1:0]      out_data_reg, out_data_next;

    logic                  accept;
    action_t               act;
    logic [IDX_W-1:0]      bidx;
    logic [CNT_W-1:0]      limit;
    logic [IDX_W-1:0]      second;
    logic [IDX_W-1:0]      rd_data;

    logic                  we;
    logic [CNT_W-1:0]      waddr_full;
    logic [IDX_W-1:0]      waddr;
    logic [CNT_W-1:0]      raddr_full;
    logic [IDX_W-1:0]      raddr;

    status_t               status;
    logic                  grant;
    logic [IDX_W-1:0]      gidx;
    logic [CNT_W-1:0]      untouched_dec;
    logic [21:0]           prod;
    logic [ADDR_W-1:0]     gaddr;

    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign act           = action_t'(s_axis_tdata[1:0]);
    assign bidx          = s_axis_tdata[7:2];
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    assign limit      = (count_reg > CNT_W'(MAX_BLOCKS)) ? CNT_W'(MAX_BLOCKS) : count_reg;
    assign second     = byp_reg ? byp_data_reg : rd_data;
    assign waddr_full = depth_reg - CNT_W'(1);
    assign waddr      = waddr_full[IDX_W-1:0];
    assign untouched_dec = untouched_reg - CNT_W'(1);

    always_comb
    begin
        depth_next     = depth_reg;
        untouched_next = untouched_reg;
        marks_next     = marks_reg;
        tos_next       = tos_reg;
        we             = 1'b0;
        status         = ST_OK;
        grant          = 1'b0;
        gidx           = '0;
        if (accept)
        begin
            unique case (act)
                ACT_INIT:
                begin
                    for (int i = 0; i < MAX_BLOCKS; i++)
                    begin
                        marks_next[i] = (CNT_W'(i) < limit);
                    end
                    depth_next     = '0;
                    untouched_next = limit;
                end
                ACT_GET:
                begin
                    if (depth_reg != '0)
                    begin
                        grant      = 1'b1;
                        gidx       = tos_reg;
                        depth_next = waddr_full;
                        tos_next   = second;
                        marks_next[tos_reg] = 1'b0;
                    end
                    else if (untouched_reg != '0)
                    begin
                        grant          = 1'b1;
                        gidx           = untouched_dec[IDX_W-1:0];
                        untouched_next = untouched_dec;
                        marks_next[untouched_dec[IDX_W-1:0]] = 1'b0;
                    end
                    else
                    begin
                        status = ST_EMPTY;
                    end
                end
                ACT_FREE:
                begin
                    if ({1'b0, bidx} >= limit)
                    begin
                        status = ST_RANGE;
                    end
                    else if (marks_reg[bidx])
                    begin
                        status = ST_DOUBLE;
                    end
                    else if (depth_reg < CNT_W'(MAX_BLOCKS))
                    begin
                        we               = (depth_reg != '0);
                        tos_next         = bidx;
                        depth_next       = depth_reg + CNT_W'(1);
                        marks_next[bidx] = 1'b1;
                    end
                end
                ACT_NOP:
                begin
                end
                default:
                begin
                end
            endcase
        end
    end

    // ram read runs at the next depth so the entry below the top is ready
    assign raddr_full = depth_next - CNT_W'(2);
    assign raddr      = raddr_full[IDX_W-1:0];
    assign byp_next   = we && (waddr == raddr);

    assign prod  = {{(22-IDX_W){1'b0}}, gidx} * {{(22-SIZE_W){1'b0}}, size_reg};
    assign gaddr = grant ? (base_reg + {{(ADDR_W-22){1'b0}}, prod}) : '0;
    assign out_data_next = {gaddr, gidx, status};

    fbfl_ram #(
        .WIDTH (IDX_W),
        .DEPTH (MAX_BLOCKS)
    ) u_stack_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (tos_reg),
        .raddr (raddr),
        .rdata (rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg  <= '0;
            size_reg  <= SIZE_W'(8);
            count_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_index))
                CFG_BASE_ADDRESS: base_reg  <= cfg_data[ADDR_W-1:0];
                CFG_BLOCK_SIZE:   size_reg  <= cfg_data[SIZE_W-1:0];
                CFG_BLOCK_COUNT:  count_reg <= cfg_data[CNT_W-1:0];
                CFG_UNUSED:       ;
                default:          ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            depth_reg     <= '0;
            untouched_reg <= '0;
            marks_reg     <= '0;
            byp_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            depth_reg     <= depth_next;
            untouched_reg <= untouched_next;
            marks_reg     <= marks_next;
            byp_reg       <= byp_next;
            if (accept)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        tos_reg      <= tos_next;
        byp_data_reg <= tos_reg;
        if (accept)
        begin
            out_data_reg <= out_data_next;
        end
    end

endmodule

// ===== tb/sv/tb_fixed_block_free_list_allocator.sv =====
// testbench: fixed block free list allocator against its own pool predictor
`timescale 1ns / 1ps

module tb_fixed_block_free_list_allocator;
    import fbfl_pkg::*;

    localparam int RESET_CYCLES    = 7;
    localparam int WATCHDOG_LIMIT  = 4000;
    localparam int RANDOM_PHASES   = 8;
    localparam int PHASE_REQUESTS  = 228;
    localparam int MAX_REPORTS     = 40;

    typedef struct {
        status_t            status;
        logic [IDX_W-1:0]   index;
        logic [ADDR_W-1:0]  address;
    } grant_t;

    class alloc_checker;
        logic [ADDR_W-1:0] base_address;
        logic [SIZE_W-1:0] block_bytes;
        logic [CNT_W-1:0]  block_count;
        logic [IDX_W-1:0]  freed_stack [MAX_BLOCKS];
        int unsigned       stack_depth;
        int unsigned       untouched;
        bit [MAX_BLOCKS-1:0] free_marks;
        grant_t            expected_grants [$];
        int unsigned       mismatches;
        int unsigned       status_seen [4];

        function new();
            base_address = '0;
            block_bytes  = SIZE_W'(8);
            block_count  = '0;
            stack_depth  = 0;
            untouched    = 0;
            free_marks   = '0;
            mismatches   = 0;
            foreach (status_seen[i])
                status_seen[i] = 0;
        endfunction

        function void write_reg(cfg_reg_t r, logic [CFG_W-1:0] v);
            case (r)
                CFG_BASE_ADDRESS: base_address = v[ADDR_W-1:0];
                CFG_BLOCK_SIZE:   block_bytes  = v[SIZE_W-1:0];
                CFG_BLOCK_COUNT:  block_count  = v[CNT_W-1:0];
                default: ;
            endcase
        endfunction

        function int unsigned pool_blocks();
            return (block_count > MAX_BLOCKS) ? MAX_BLOCKS : block_count;
        endfunction

        // a block currently handed out, if there is one, so that a free of it is accepted
        function logic [IDX_W-1:0] pick_held_block();
            int unsigned n;
            int unsigned start;
            n = pool_blocks();
            if (n == 0)
                return IDX_W'($urandom_range(MAX_BLOCKS - 1));
            start = $urandom_range(n - 1);
            for (int k = 0; k < n; k++)
                if (!free_marks[(start + k) % n])
                    return IDX_W'((start + k) % n);
            return IDX_W'(start);
        endfunction

        function void note_request(action_t act, logic [IDX_W-1:0] idx);
            grant_t      g;
            int unsigned n;
            g.status  = ST_OK;
            g.index   = '0;
            g.address = '0;
            case (act)
                ACT_INIT:
                begin
                    n = pool_blocks();
                    free_marks = '0;
                    for (int i = 0; i < n; i++)
                        free_marks[i] = 1'b1;
                    stack_depth = 0;
                    untouched   = n;
                end
                ACT_GET:
                begin
                    if (stack_depth > 0)
                    begin
                        stack_depth--;
                        g.index = freed_stack[stack_depth];
                    end
                    else if (untouched > 0)
                    begin
                        untouched--;
                        g.index = IDX_W'(untouched);
                    end
                    else
                        g.status = ST_EMPTY;
                    if (g.status == ST_OK)
                    begin
                        free_marks[g.index] = 1'b0;
                        g.address = base_address + ADDR_W'(g.index) * ADDR_W'(block_bytes);
                    end
                end
                ACT_FREE:
                begin
                    if (idx >= pool_blocks())
                        g.status = ST_RANGE;
                    else if (free_marks[idx])
                        g.status = ST_DOUBLE;
                    else if (stack_depth < MAX_BLOCKS)
                    begin
                        freed_stack[stack_depth] = idx;
                        stack_depth++;
                        free_marks[idx] = 1'b1;
                    end
                end
                default: ;
            endcase
            expected_grants.push_back(g);
        endfunction

        function void report(string what, logic [ADDR_W-1:0] want, logic [ADDR_W-1:0] got);
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("[%0t] %s mismatch: expected 0x%0h, actual 0x%0h",
                         $time, what, want, got);
        endfunction

        function void check_grant(logic [OUT_W-1:0] data);
            grant_t want;
            if (expected_grants.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("[%0t] unexpected transaction: expected none, actual 0x%0h",
                             $time, data);
                return;
            end
            want = expected_grants.pop_front();
            status_seen[want.status]++;
            if (data[1:0] !== want.status)
                report("status", ADDR_W'(want.status), ADDR_W'(data[1:0]));
            if (data[7:2] !== want.index)
                report("granted_index", ADDR_W'(want.index), ADDR_W'(data[7:2]));
            if (data[39:8] !== want.address)
                report("granted_address", want.address, data[39:8]);
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0] cfg_data = '0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [IN_W-1:0] s_axis_tdata = '0;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [OUT_W-1:0] m_axis_tdata;

    alloc_checker pool = new();
    int unsigned send_idle_pct = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned quiet_cycles = 0;
    int unsigned requests_sent = 0;

    fixed_block_free_list_allocator DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(negedge clk)
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);

    // results are checked before new requests are noted at the same edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
                pool.check_grant(m_axis_tdata);
            if (s_axis_tvalid && s_axis_tready)
                pool.note_request(action_t'(s_axis_tdata[1:0]), s_axis_tdata[7:2]);
        end
        if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready) || cfg_we)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == WATCHDOG_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    task automatic send_request(action_t act, logic [IDX_W-1:0] idx);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {idx, act};
        do
            @(posedge clk);
        while (!s_axis_tready);
        requests_sent++;
    endtask

    task automatic write_register(cfg_reg_t r, logic [CFG_W-1:0] v);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= r;
        cfg_data  <= v;
        @(posedge clk);
        pool.write_reg(r, v);
    endtask

    task automatic settle();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        cfg_we        <= 1'b0;
        while (pool.expected_grants.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic configure(logic [ADDR_W-1:0] base, logic [SIZE_W-1:0] bsize,
                             logic [CNT_W-1:0] count);
        settle();
        write_register(CFG_BASE_ADDRESS, CFG_W'(base));
        write_register(CFG_BLOCK_SIZE, CFG_W'(bsize));
        write_register(CFG_BLOCK_COUNT, CFG_W'(count));
        settle();
    endtask

    // mostly gets and frees of held blocks, with stray frees, inits and nops mixed in
    task automatic random_request();
        int unsigned      roll;
        int unsigned      pick;
        logic [IDX_W-1:0] idx;
        roll = $urandom_range(99);
        idx  = IDX_W'($urandom_range(MAX_BLOCKS - 1));
        if (roll < 3)
            send_request(ACT_INIT, idx);
        else if (roll < 6)
            send_request(ACT_NOP, idx);
        else if (roll < 50)
            send_request(ACT_GET, idx);
        else
        begin
            pick = $urandom_range(9);
            if (pick < 6)
                idx = pool.pick_held_block();
            send_request(ACT_FREE, idx);
        end
    endtask

    initial
    begin
        logic [ADDR_W-1:0] base;
        logic [SIZE_W-1:0] bsize;
        logic [CNT_W-1:0]  count;

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: empty pool, free before init, double free, range, unused action
        configure(32'h0000_1000, 16'd16, 7'd4);
        write_register(CFG_UNUSED, {CFG_W{1'b1}});
        settle();
        send_request(ACT_GET, 6'd0);
        send_request(ACT_FREE, 6'd0);
        send_request(ACT_FREE, 6'd0);
        send_request(ACT_FREE, 6'd63);
        send_request(ACT_NOP, 6'd63);
        send_request(ACT_INIT, 6'd0);
        send_request(ACT_FREE, 6'd2);
        repeat (5) send_request(ACT_GET, 6'd0);
        send_request(ACT_FREE, 6'd1);
        send_request(ACT_FREE, 6'd3);
        send_request(ACT_GET, 6'd0);
        send_request(ACT_GET, 6'd0);

        // largest pool with address wrap
        configure(32'hFFFF_FFFF, 16'hFFFF, 7'd64);
        send_request(ACT_INIT, 6'd0);
        send_request(ACT_GET, 6'd0);
        send_request(ACT_FREE, 6'd63);
        send_request(ACT_FREE, 6'd63);
        send_request(ACT_FREE, 6'd0);
        send_request(ACT_GET, 6'd0);

        // count above the pool size is clamped
        configure(32'h8000_0000, 16'd1, 7'd127);
        send_request(ACT_INIT, 6'd0);
        send_request(ACT_GET, 6'd0);
        send_request(ACT_FREE, 6'd63);

        // zero blocks
        configure(32'h0, 16'd1, 7'd0);
        send_request(ACT_INIT, 6'd0);
        send_request(ACT_GET, 6'd0);
        send_request(ACT_FREE, 6'd0);

        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            base  = $urandom;
            bsize = SIZE_W'($urandom_range(65535, 1));
            count = CNT_W'($urandom_range(64, 1));
            case (p)
                0: begin base = 32'h0; bsize = 16'd1; count = 7'd64; end
                1: begin base = 32'hFFFF_FFFF; bsize = 16'hFFFF; count = 7'd64; end
                2: begin bsize = 16'd8; count = 7'd1; end
                3: count = 7'd5;
                4: begin bsize = 16'hFFFF; count = 7'd37; end
                5: count = 7'd0;
                6: count = 7'd127;
                default: ;
            endcase
            case (p % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 85; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 85; end
                default: begin send_idle_pct = 23; recv_stall_pct = 23; end
            endcase
            configure(base, bsize, count);
            // now and then keep the old pool contents under the new settings
            if ($urandom_range(3) != 0)
                send_request(ACT_INIT, IDX_W'($urandom_range(MAX_BLOCKS - 1)));
            repeat (PHASE_REQUESTS) random_request();
        end

        settle();
        repeat (8) @(posedge clk);
        $display("ran %0d requests over %0d pool settings with random gaps and stalls",
                 requests_sent, RANDOM_PHASES + 4);
        $display("results: %0d ok, %0d empty, %0d double free, %0d out of range",
                 pool.status_seen[ST_OK], pool.status_seen[ST_EMPTY],
                 pool.status_seen[ST_DOUBLE], pool.status_seen[ST_RANGE]);
        if (pool.mismatches == 0 && pool.expected_grants.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
